// ===== rtl/core/rsa_pkg.sv =====
package rsa_pkg;

   localparam int unsigned DimW   = 13;
   localparam int unsigned PageW  = 8;
   localparam int unsigned PosW   = 12;
   localparam int unsigned CountW = 9;

   localparam logic [DimW-1:0] PageSizeReset = 13'd1024;
   localparam int unsigned     SideHardCap   = 4096;
   localparam int unsigned     PageHardCap   = 256;

   typedef struct packed {
      logic             page_class;
      logic [DimW-1:0]  rect_width;
      logic [DimW-1:0]  rect_height;
   } req_word_type;

   typedef struct packed {
      logic             placed;
      logic [PageW-1:0] page_number;
      logic [PosW-1:0]  pos_x;
      logic [PosW-1:0]  pos_y;
   } rsp_word_type;

   typedef struct packed {
      logic             open;
      logic [PageW-1:0] page;
      logic [DimW-1:0]  col;
      logic [DimW-1:0]  row;
      logic [DimW-1:0]  shelf;
   } class_state_type;

   typedef struct packed {
      logic update;
      logic take_page;
   } place_ctrl_type;

endpackage

// ===== rtl/core/shelf_rect_allocator_unit.sv =====
// Shelf rectangle allocator.
// A request word waits in the request register until the result register is free,
// then moves in and raises rsp_valid; one word per clock while rsp_ready drains it.
// Each class's cursor update is a single compare-and-add pass between the two registers.
// Reset (synchronous, active high) closes both classes, clears the page counter,
// sets page_size to 1024 and empties both registers.
module shelf_rect_allocator_unit #(
   parameter int unsigned MAX_PAGES     = 256,
   parameter int unsigned MAX_PAGE_SIZE = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rsa_pkg::DimW-1:0]    csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_page_class,
   input  logic [rsa_pkg::DimW-1:0]    req_rect_width,
   input  logic [rsa_pkg::DimW-1:0]    req_rect_height,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_placed,
   output logic [rsa_pkg::PageW-1:0]   rsp_page_number,
   output logic [rsa_pkg::PosW-1:0]    rsp_pos_x,
   output logic [rsa_pkg::PosW-1:0]    rsp_pos_y
);
   import rsa_pkg::*;

   localparam int unsigned SideCap   = (MAX_PAGE_SIZE < SideHardCap) ? MAX_PAGE_SIZE
                                                                    : SideHardCap;
   localparam int unsigned PageLimit = (MAX_PAGES < PageHardCap) ? MAX_PAGES
                                                                 : PageHardCap;
   localparam logic [DimW-1:0]   SideCapW   = DimW'(SideCap);
   localparam logic [CountW-1:0] PageLimitW = CountW'(PageLimit);

   logic [DimW-1:0]   page_size_ff;
   logic              in_vld_ff;
   req_word_type      in_word_ff;
   logic              out_vld_ff;
   rsp_word_type      out_word_ff;
   class_state_type   cls_ff [2];
   logic [CountW-1:0] pages_used_ff;
   logic [CountW-1:0] pages_used_in;

   logic              move;
   logic [DimW-1:0]   side;
   rsp_word_type      place_rsp;
   class_state_type   place_next;
   place_ctrl_type    place_ctrl;

   assign side = (page_size_ff > SideCapW) ? SideCapW : page_size_ff;

   // A word moves into the result register whenever that register is empty
   // or is being emptied in this cycle.
   assign move      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || move;

   rsa_place u_place (
      .item       (in_word_ff),
      .cur_state  (cls_ff[in_word_ff.page_class]),
      .side       (side),
      .pages_used (pages_used_ff),
      .page_limit (PageLimitW),
      .result     (place_rsp),
      .next_state (place_next),
      .ctrl       (place_ctrl)
   );

   assign pages_used_in = pages_used_ff + CountW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= PageSizeReset;
      end else if (csr_wr_en) begin
         page_size_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff.page_class  <= req_page_class;
         in_word_ff.rect_width  <= req_rect_width;
         in_word_ff.rect_height <= req_rect_height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (move) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_word_ff <= place_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff[0]     <= '0;
         cls_ff[1]     <= '0;
         pages_used_ff <= '0;
      end else if (move) begin
         if (place_ctrl.update) begin
            cls_ff[in_word_ff.page_class] <= place_next;
         end
         if (place_ctrl.take_page) begin
            pages_used_ff <= pages_used_in;
         end
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_placed      = out_word_ff.placed;
   assign rsp_page_number = out_word_ff.page_number;
   assign rsp_pos_x       = out_word_ff.pos_x;
   assign rsp_pos_y       = out_word_ff.pos_y;

   a_page_count_bound: assert property (@(posedge clock) disable iff (reset)
      pages_used_ff <= PageLimitW)
      else $error("page counter ran past the page limit");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_word_ff.placed) |->
         (out_word_ff.page_number == '0 && out_word_ff.pos_x == '0 &&
          out_word_ff.pos_y == '0))
      else $error("rejected word carries a nonzero position");

   a_class_opens: assert property (@(posedge clock) disable iff (reset)
      (move && place_rsp.placed) |=> cls_ff[$past(in_word_ff.page_class)].open)
      else $error("class not open after a placement");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(pages_used_ff))
      else $error("page counter changed without a word moving");

endmodule

// ===== rtl/core/rsa_place.sv =====
module rsa_place (
   input  rsa_pkg::req_word_type        item,
   input  rsa_pkg::class_state_type     cur_state,
   input  logic [rsa_pkg::DimW-1:0]     side,
   input  logic [rsa_pkg::CountW-1:0]   pages_used,
   input  logic [rsa_pkg::CountW-1:0]   page_limit,
   output rsa_pkg::rsp_word_type        result,
   output rsa_pkg::class_state_type     next_state,
   output rsa_pkg::place_ctrl_type      ctrl
);
   import rsa_pkg::*;

   logic [DimW-1:0] w;
   logic [DimW-1:0] h;
   logic            bad_size;
   logic            wrap;
   logic [DimW-1:0] col_a;
   logic [DimW:0]   row_a;
   logic [DimW-1:0] shelf_a;
   logic            need_page;
   logic            no_page;
   logic            ok;
   logic [PageW-1:0] page_f;
   logic [DimW-1:0] col_f;
   logic [DimW:0]   row_f;
   logic [DimW-1:0] shelf_f;
   logic [DimW:0]   col_end;
   logic [DimW+1:0] row_end;

   assign w = item.rect_width;
   assign h = item.rect_height;

   assign bad_size = (w == '0) || (h == '0) || (w > side) || (h > side);

   // A full row moves the cursor down onto a new shelf.
   assign col_end = {1'b0, cur_state.col} + {1'b0, w};
   assign wrap    = cur_state.open && (col_end > {1'b0, side});
   assign col_a   = wrap ? '0 : cur_state.col;
   assign row_a   = wrap ? ({1'b0, cur_state.row} + {1'b0, cur_state.shelf})
                         : {1'b0, cur_state.row};
   assign shelf_a = wrap ? '0 : cur_state.shelf;

   assign row_end   = {1'b0, row_a} + {2'b00, h};
   assign need_page = !cur_state.open || (row_end > {2'b00, side});
   assign no_page   = need_page && (pages_used >= page_limit);
   assign ok        = !bad_size && !no_page;

   assign page_f  = need_page ? pages_used[PageW-1:0] : cur_state.page;
   assign col_f   = need_page ? '0 : col_a;
   assign row_f   = need_page ? '0 : row_a;
   assign shelf_f = need_page ? '0 : shelf_a;

   always_comb begin
      next_state.open  = 1'b1;
      next_state.page  = page_f;
      next_state.col   = col_f + w;
      next_state.row   = row_f[DimW-1:0];
      next_state.shelf = (h > shelf_f) ? h : shelf_f;

      result.placed      = ok;
      result.page_number = ok ? page_f : '0;
      result.pos_x       = ok ? col_f[PosW-1:0] : '0;
      result.pos_y       = ok ? row_f[PosW-1:0] : '0;

      ctrl.update    = ok;
      ctrl.take_page = ok && need_page;
   end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MaxPages    = 256;
   localparam int unsigned MaxPageSize = 4096;
   localparam int unsigned CycleLimit  = 300000;
   localparam int unsigned PhaseCount  = 8;
   localparam logic        ClassMono   = 1'b0;
   localparam logic        ClassColor  = 1'b1;

   // Tracks the packing state of both classes and holds the placements still owed.
   class placement_checker;
      int unsigned page_cap;
      int unsigned side_cap;
      logic [rsa_pkg::DimW-1:0] page_size;
      rsa_pkg::class_state_type shelves[2];
      logic [rsa_pkg::CountW-1:0] pages_used;
      rsa_pkg::rsp_word_type placements_due[$];
      int unsigned mismatches;

      function new(int unsigned pages, int unsigned side_max);
         page_cap = pages > rsa_pkg::PageHardCap ? rsa_pkg::PageHardCap : pages;
         side_cap = side_max > rsa_pkg::SideHardCap ? rsa_pkg::SideHardCap : side_max;
         page_size = rsa_pkg::PageSizeReset;
         shelves[0] = '0;
         shelves[1] = '0;
         pages_used = '0;
         mismatches = 0;
      endfunction

      function void set_page_size(logic [rsa_pkg::DimW-1:0] value);
         page_size = value;
      endfunction

      function int unsigned pending();
         return placements_due.size();
      endfunction

      function void note_request(rsa_pkg::req_word_type rq);
         int unsigned side, w, h, col, row, shelf;
         logic [rsa_pkg::PageW-1:0] page;
         bit fresh, ok;
         rsa_pkg::rsp_word_type res;
         side = page_size > side_cap ? side_cap : page_size;
         w = rq.rect_width;
         h = rq.rect_height;
         res = '0;
         ok = (w != 0) && (h != 0) && (w <= side) && (h <= side);
         if (ok) begin
            col = shelves[rq.page_class].col;
            row = shelves[rq.page_class].row;
            shelf = shelves[rq.page_class].shelf;
            page = shelves[rq.page_class].page;
            fresh = !shelves[rq.page_class].open;
            if (!fresh) begin
               if (col + w > side) begin
                  col = 0;
                  row = row + shelf;
                  shelf = 0;
               end
               if (row + h > side) fresh = 1'b1;
            end
            // A new page is only taken while the shared counter has room left;
            // otherwise the class keeps its old cursor untouched.
            if (fresh) begin
               if (pages_used < page_cap) begin
                  page = pages_used[rsa_pkg::PageW-1:0];
                  pages_used = pages_used + 1'b1;
                  col = 0;
                  row = 0;
                  shelf = 0;
               end else begin
                  ok = 1'b0;
               end
            end
         end
         if (ok) begin
            res.placed = 1'b1;
            res.page_number = page;
            res.pos_x = col[rsa_pkg::PosW-1:0];
            res.pos_y = row[rsa_pkg::PosW-1:0];
            shelves[rq.page_class].open = 1'b1;
            shelves[rq.page_class].page = page;
            shelves[rq.page_class].col = rsa_pkg::DimW'(col + w);
            shelves[rq.page_class].row = rsa_pkg::DimW'(row);
            shelves[rq.page_class].shelf = rsa_pkg::DimW'(h > shelf ? h : shelf);
         end
         placements_due = {placements_due, res};
      endfunction

      function void check_placement(rsa_pkg::rsp_word_type got);
         rsa_pkg::rsp_word_type want;
         if (placements_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: placed=%0d page=%0d x=%0d y=%0d",
                        got.placed, got.page_number, got.pos_x, got.pos_y);
            return;
         end
         want = placements_due.pop_front();
         if (got.placed !== want.placed || got.page_number !== want.page_number ||
             got.pos_x !== want.pos_x || got.pos_y !== want.pos_y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected placed=%0d page=%0d x=%0d y=%0d,",
                        want.placed, want.page_number, want.pos_x, want.pos_y,
                        " got placed=%0d page=%0d x=%0d y=%0d",
                        got.placed, got.page_number, got.pos_x, got.pos_y);
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [rsa_pkg::DimW-1:0]   csr_wr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_page_class = 1'b0;
   logic [rsa_pkg::DimW-1:0]   req_rect_width = '0;
   logic [rsa_pkg::DimW-1:0]   req_rect_height = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_placed;
   logic [rsa_pkg::PageW-1:0]  rsp_page_number;
   logic [rsa_pkg::PosW-1:0]   rsp_pos_x;
   logic [rsa_pkg::PosW-1:0]   rsp_pos_y;

   int unsigned send_idle = 36;
   int unsigned recv_idle = 76;
   int unsigned cycle_count = 0;

   placement_checker board = new(MaxPages, MaxPageSize);

   shelf_rect_allocator_unit #(
      .MAX_PAGES(MaxPages),
      .MAX_PAGE_SIZE(MaxPageSize)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_page_class(req_page_class),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_placed(rsp_placed),
      .rsp_page_number(rsp_page_number),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request('{req_page_class, req_rect_width, req_rect_height});
         if (rsp_valid && rsp_ready)
            board.check_placement('{rsp_placed, rsp_page_number, rsp_pos_x, rsp_pos_y});
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Valid stays high from one word to the next unless the sender takes a gap.
   task automatic send_req(input rsa_pkg::req_word_type rq);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page_class <= rq.page_class;
      req_rect_width <= rq.rect_width;
      req_rect_height <= rq.rect_height;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // The first edge lets the monitor note a word taken at the edge this task starts on.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_page_size(input logic [rsa_pkg::DimW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      board.set_page_size(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly small rectangles so a page holds many; a few large, zero or oversize ones.
   function automatic logic [rsa_pkg::DimW-1:0] pick_dim(input int unsigned side);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return '0;
      if (roll < 8) return rsa_pkg::DimW'($urandom_range(side + 1, 8191));
      if (roll < 12) return rsa_pkg::DimW'($urandom_range(1, side > 1 ? side : 1));
      return rsa_pkg::DimW'($urandom_range(1, side > 5 ? side / 6 : 1));
   endfunction

   rsa_pkg::req_word_type opening_reqs[13] = '{
      '{ClassMono,  13'd0,    13'd5},
      '{ClassMono,  13'd5,    13'd0},
      '{ClassMono,  13'd1025, 13'd1},
      '{ClassColor, 13'd1,    13'd8191},
      '{ClassMono,  13'd8191, 13'd8191},
      '{ClassMono,  13'd4096, 13'd4096},
      '{ClassMono,  13'd1,    13'd1},
      '{ClassColor, 13'd1024, 13'd1024},
      '{ClassColor, 13'd1,    13'd1},
      '{ClassMono,  13'd1023, 13'd10},
      '{ClassMono,  13'd5,    13'd20},
      '{ClassMono,  13'd1024, 13'd994},
      '{ClassMono,  13'd1,    13'd1}
   };

   // The small sizes come last: they use up the shared pages and end in rejection.
   logic [rsa_pkg::DimW-1:0] phase_sizes[PhaseCount] = '{
      13'd4096, 13'd8191, 13'd0, 13'd0, 13'd300, 13'd64, 13'd2, 13'd1
   };
   int unsigned phase_lengths[PhaseCount] = '{250, 250, 250, 30, 200, 200, 120, 200};

   initial begin
      int unsigned side;
      rsa_pkg::req_word_type rq;
      phase_sizes[2] = rsa_pkg::DimW'($urandom_range(200, 4095));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening_reqs[i]) send_req(opening_reqs[i]);
      for (int ph = 0; ph < PhaseCount; ph++) begin
         if (ph == 3) begin
            send_idle = 76;
            recv_idle = 36;
         end else if (ph == 6) begin
            send_idle = 0;
            recv_idle = 0;
         end
         settle();
         write_page_size(phase_sizes[ph]);
         side = phase_sizes[ph] > MaxPageSize ? MaxPageSize : phase_sizes[ph];
         for (int k = 0; k < phase_lengths[ph]; k++) begin
            rq.page_class = 1'($urandom_range(0, 1));
            rq.rect_width = pick_dim(side);
            rq.rect_height = pick_dim(side);
            send_req(rq);
         end
      end
      settle();
      repeat (5) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
